// ----- rtl/vlmd_pkg.sv -----
// ----------------------------------------------------------------------------
// vlmd_pkg
// Shared types and constants for the varint length message deframer.
// ----------------------------------------------------------------------------
package vlmd_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 32;
   localparam int KIND_W     = 2;
   localparam int LEN_CNT_W  = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [BYTE_W-1:0] DATA_MASK = 8'd127;
   localparam logic [BYTE_W-1:0] MORE_MASK = 8'd128;

   typedef enum logic [KIND_W-1:0] {
      KIND_HDR = 2'd0,
      KIND_PAY = 2'd1,
      KIND_ERR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_TYPE = 3'b001,
      PH_LEN  = 3'b010,
      PH_PAY  = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTE_W-1:0]     msg_class;
      logic [LEN_W-1:0]      payload_len;
      logic [BYTE_W-1:0]     payload_byte;
      logic                  last;
   } result_type;

endpackage

// ----- rtl/vlmd_front.sv -----
// ----------------------------------------------------------------------------
// vlmd_front
// Byte parser: tracks message phase, decodes the base-128 length and
// produces at most one result record per transferred byte.
// ----------------------------------------------------------------------------
module vlmd_front #(
   parameter int MAX_LEN_BYTES = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [vlmd_pkg::BYTE_W-1:0] in_byte,
   output logic                        res_valid,
   output vlmd_pkg::result_type        res
);

   vlmd_pkg::phase_type                phase_ff, phase_in;
   logic [vlmd_pkg::BYTE_W-1:0]        type_hold_ff, type_hold_in;
   logic [vlmd_pkg::LEN_W-1:0]         length_accum_ff, length_accum_in;
   logic [vlmd_pkg::LEN_CNT_W-1:0]     len_count_ff, len_count_in;
   logic [vlmd_pkg::LEN_W-1:0]         remaining_ff, remaining_in;

   logic [5:0]                         shift;
   logic [vlmd_pkg::LEN_W+6:0]         part;
   logic [vlmd_pkg::LEN_W-1:0]         len_new;

   always_comb begin
      shift   = 6'(len_count_ff) * 6'd7;
      part    = (vlmd_pkg::LEN_W+7)'(in_byte & vlmd_pkg::DATA_MASK) << shift;
      len_new = length_accum_ff;
      if (shift < 6'd32) begin
         len_new = length_accum_ff | part[vlmd_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      type_hold_in    = type_hold_ff;
      length_accum_in = length_accum_ff;
      len_count_in    = len_count_ff;
      remaining_in    = remaining_ff;
      res_valid       = 1'b0;
      res             = '0;
      res.msg_class   = type_hold_ff;
      if (accept) begin
         unique case (phase_ff)
            vlmd_pkg::PH_LEN: begin
               length_accum_in = len_new;
               len_count_in    = len_count_ff + 1'b1;
               if ((in_byte & vlmd_pkg::MORE_MASK) == '0) begin
                  res_valid       = 1'b1;
                  res.kind        = vlmd_pkg::KIND_HDR;
                  res.payload_len = len_new;
                  res.last        = (len_new == '0);
                  remaining_in    = len_new;
                  phase_in        = (len_new == '0) ? vlmd_pkg::PH_TYPE : vlmd_pkg::PH_PAY;
               end else if (len_count_in >= vlmd_pkg::LEN_CNT_W'(MAX_LEN_BYTES)) begin
                  res_valid = 1'b1;
                  res.kind  = vlmd_pkg::KIND_ERR;
                  phase_in  = vlmd_pkg::PH_TYPE;
               end
            end
            vlmd_pkg::PH_PAY: begin
               res_valid        = 1'b1;
               res.kind         = vlmd_pkg::KIND_PAY;
               res.payload_byte = in_byte;
               res.last         = (remaining_ff <= vlmd_pkg::LEN_W'(1));
               if (res.last) begin
                  remaining_in = '0;
                  phase_in     = vlmd_pkg::PH_TYPE;
               end else begin
                  remaining_in = remaining_ff - 1'b1;
               end
            end
            default: begin
               type_hold_in    = in_byte;
               length_accum_in = '0;
               len_count_in    = '0;
               remaining_in    = '0;
               phase_in        = vlmd_pkg::PH_LEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= vlmd_pkg::PH_TYPE;
         type_hold_ff    <= '0;
         length_accum_ff <= '0;
         len_count_ff    <= '0;
         remaining_ff    <= '0;
      end else begin
         phase_ff        <= phase_in;
         type_hold_ff    <= type_hold_in;
         length_accum_ff <= length_accum_in;
         len_count_ff    <= len_count_in;
         remaining_ff    <= remaining_in;
      end
   end

endmodule

// ----- rtl/vlmd_queue.sv -----
// ----------------------------------------------------------------------------
// vlmd_queue
// Short result queue between the parser and the result port.
// ----------------------------------------------------------------------------
module vlmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  vlmd_pkg::result_type wr_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output vlmd_pkg::result_type rd_data
);

   localparam int PTR_W = $clog2(vlmd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(vlmd_pkg::QUEUE_DEPTH + 1);

   vlmd_pkg::result_type mem [vlmd_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(vlmd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = pop & ~empty;
   assign rd_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/varint_length_message_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// varint_length_message_deframer_unit
// Splits a byte stream of type / LEB128 length / payload messages into
// header, payload-byte and error results.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        req_in_byte
//  result    pop / empty        rsp_out_kind, rsp_msg_class, rsp_payload_len_out,
//                               rsp_payload_byte, rsp_last_of_message
//
//  One byte per clock; a byte's result is written to a four-entry queue in the
//  cycle of its transfer; into an empty queue it is on the result ports from the next cycle.
//  full rises only when four results wait untaken; the parser stalls then.
//  Synchronous active-high reset returns to waiting for a type byte and
//  empties the queue.
// ----------------------------------------------------------------------------
module varint_length_message_deframer_unit #(
   parameter int MAX_LEN_BYTES = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [vlmd_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic [vlmd_pkg::KIND_W-1:0]   rsp_out_kind,
   output logic [vlmd_pkg::BYTE_W-1:0]   rsp_msg_class,
   output logic [vlmd_pkg::LEN_W-1:0]    rsp_payload_len_out,
   output logic [vlmd_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic                          rsp_last_of_message
);

   logic                 accept;
   logic                 res_valid;
   vlmd_pkg::result_type res;
   vlmd_pkg::result_type head;

   assign accept = push & ~full;

   vlmd_front #(
      .MAX_LEN_BYTES (MAX_LEN_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   vlmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid),
      .wr_data (res),
      .full    (full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (head)
   );

   assign rsp_out_kind        = head.kind;
   assign rsp_msg_class       = head.msg_class;
   assign rsp_payload_len_out = head.payload_len;
   assign rsp_payload_byte    = head.payload_byte;
   assign rsp_last_of_message = head.last;

endmodule

// ----- sim/varint_length_message_deframer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// varint_length_message_deframer_unit_tb
// Self-checking bench for the LEB128 length-prefixed deframer. A driver pushes
// a byte stream of directed and random messages with random idle gaps. A
// predictor parses the same bytes into expected header, payload and error
// results. A monitor pops results under random stalls and checks each one
// against the oldest expected result.
// ----------------------------------------------------------------------------
module varint_length_message_deframer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN_BYTES = 5;
   localparam int RANDOM_BYTES  = 950;
   localparam int IDLE_LIMIT    = 2000;
   localparam int DRAIN_CYCLES  = 8;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                push = 1'b0;
   logic                                full;
   logic [vlmd_pkg::BYTE_W-1:0]         req_in_byte = '0;
   logic                                empty;
   logic                                pop = 1'b0;
   logic [vlmd_pkg::KIND_W-1:0]         rsp_out_kind;
   logic [vlmd_pkg::BYTE_W-1:0]         rsp_msg_class;
   logic [vlmd_pkg::LEN_W-1:0]          rsp_payload_len_out;
   logic [vlmd_pkg::BYTE_W-1:0]         rsp_payload_byte;
   logic                                rsp_last_of_message;

   varint_length_message_deframer_unit #(
      .MAX_LEN_BYTES(MAX_LEN_BYTES)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_in_byte         (req_in_byte),
      .empty               (empty),
      .pop                 (pop),
      .rsp_out_kind        (rsp_out_kind),
      .rsp_msg_class       (rsp_msg_class),
      .rsp_payload_len_out (rsp_payload_len_out),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last_of_message (rsp_last_of_message)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   logic [vlmd_pkg::BYTE_W-1:0] stream_bytes[$];
   vlmd_pkg::result_type        frames_due[$];

   // parser state of the predictor
   vlmd_pkg::phase_type            ph = vlmd_pkg::PH_TYPE;
   logic [vlmd_pkg::BYTE_W-1:0]    held_type = '0;
   logic [vlmd_pkg::LEN_W-1:0]     len_acc = '0;
   logic [vlmd_pkg::LEN_CNT_W-1:0] len_cnt = '0;
   logic [vlmd_pkg::LEN_W-1:0]     pay_left = '0;

   int unsigned errors = 0;
   int unsigned bytes_sent = 0;
   int unsigned hdr_seen = 0;
   int unsigned pay_seen = 0;
   int unsigned err_seen = 0;
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   bit          send_calm = 1'b0;
   bit          recv_calm = 1'b0;
   bit          byte_fire;
   bit          frame_fire;
   vlmd_pkg::result_type seen;

   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic deframe_byte(input logic [vlmd_pkg::BYTE_W-1:0] b);
      int unsigned shift;
      vlmd_pkg::result_type r;
      case (ph)
         vlmd_pkg::PH_LEN: begin
            shift = 7 * len_cnt;
            if (shift < vlmd_pkg::LEN_W) begin
               len_acc = len_acc |
                         (vlmd_pkg::LEN_W'(b & vlmd_pkg::DATA_MASK) << shift);
            end
            len_cnt = len_cnt + 1'b1;
            if ((b & vlmd_pkg::MORE_MASK) == '0) begin
               r = '{kind: vlmd_pkg::KIND_HDR, msg_class: held_type, payload_len: len_acc,
                     payload_byte: '0, last: (len_acc == '0)};
               frames_due.push_back(r);
               if (len_acc == '0) begin
                  ph = vlmd_pkg::PH_TYPE;
               end else begin
                  pay_left = len_acc;
                  ph = vlmd_pkg::PH_PAY;
               end
            end else if (len_cnt >= MAX_LEN_BYTES) begin
               r = '{kind: vlmd_pkg::KIND_ERR, msg_class: held_type, payload_len: '0,
                     payload_byte: '0, last: 1'b0};
               frames_due.push_back(r);
               ph = vlmd_pkg::PH_TYPE;
            end
         end
         vlmd_pkg::PH_PAY: begin
            r = '{kind: vlmd_pkg::KIND_PAY, msg_class: held_type, payload_len: '0,
                  payload_byte: b, last: (pay_left <= 1)};
            frames_due.push_back(r);
            if (pay_left <= 1) begin
               pay_left = '0;
               ph = vlmd_pkg::PH_TYPE;
            end else begin
               pay_left = pay_left - 1'b1;
            end
         end
         default: begin
            held_type = b;
            len_acc = '0;
            len_cnt = '0;
            pay_left = '0;
            ph = vlmd_pkg::PH_LEN;
         end
      endcase
   endtask

   task automatic flag(input string what);
      errors++;
      if (errors <= 10) $display("ERROR: %s", what);
   endtask

   // type byte, LEB128 length padded with extra zero groups, random payload
   task automatic add_message(input logic [vlmd_pkg::BYTE_W-1:0] t, input int unsigned len,
                              input int unsigned pad);
      int unsigned n;
      int unsigned total;
      logic [vlmd_pkg::BYTE_W-1:0] b;
      n = 1;
      while (n < MAX_LEN_BYTES && (len >> (7 * n)) != 0) n++;
      total = (n + pad > MAX_LEN_BYTES) ? MAX_LEN_BYTES : n + pad;
      stream_bytes.push_back(t);
      for (int i = 0; i < total; i++) begin
         b = vlmd_pkg::BYTE_W'((len >> (7 * i)) & 127);
         if (i < total - 1) b = b | vlmd_pkg::MORE_MASK;
         stream_bytes.push_back(b);
      end
      for (int i = 0; i < len; i++)
         stream_bytes.push_back(vlmd_pkg::BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic build_stream();
      int unsigned goal;
      int unsigned sel;
      int unsigned len;
      int unsigned pad;
      logic [vlmd_pkg::BYTE_W-1:0] first;
      // zero length, extreme bytes, length overflow, wide length, padded length
      stream_bytes = '{8'h00, 8'h00,
                       8'hFF, 8'h01, 8'hFF,
                       8'hA5, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                       8'h5A, 8'h81, 8'h80, 8'h80, 8'h80, 8'h10, 8'h00,
                       8'h3C, 8'h82, 8'h00, 8'h7F, 8'h80};
      goal = stream_bytes.size() + RANDOM_BYTES;
      while (stream_bytes.size() < goal) begin
         sel = $urandom_range(0, 99);
         if (sel < 75) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) len = 0;
            else if (sel < 85) len = $urandom_range(1, 12);
            else if (sel < 97) len = $urandom_range(13, 40);
            else len = $urandom_range(128, 300);
            pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
            add_message(vlmd_pkg::BYTE_W'($urandom_range(0, 255)), len, pad);
         end else if (sel < 87) begin
            stream_bytes.push_back(vlmd_pkg::BYTE_W'($urandom_range(0, 255)));
            repeat (MAX_LEN_BYTES)
               stream_bytes.push_back(vlmd_pkg::MORE_MASK |
                                      vlmd_pkg::BYTE_W'($urandom_range(0, 127)));
         end else begin
            // high data bits of the last group fall off the 32-bit length
            first = vlmd_pkg::MORE_MASK | vlmd_pkg::BYTE_W'($urandom_range(0, 15));
            stream_bytes.push_back(vlmd_pkg::BYTE_W'($urandom_range(0, 255)));
            stream_bytes.push_back(first);
            repeat (3) stream_bytes.push_back(vlmd_pkg::MORE_MASK);
            stream_bytes.push_back(vlmd_pkg::BYTE_W'($urandom_range(0, 7)) << 4);
            for (int i = 0; i < (first & 15); i++)
               stream_bytes.push_back(vlmd_pkg::BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
         req_in_byte <= '0;
      end else begin
         byte_fire = push && !full;
         if (byte_fire) begin
            deframe_byte(req_in_byte);
            void'(stream_bytes.pop_front());
            bytes_sent++;
            if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
         end
         if (push && !byte_fire) begin
            // hold until the transfer happens
         end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
         end else if (stream_bytes.size() > 0) begin
            push <= 1'b1;
            req_in_byte <= stream_bytes[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         frame_fire = pop && !empty;
         if (frame_fire) begin
            seen = {rsp_out_kind, rsp_msg_class, rsp_payload_len_out,
                    rsp_payload_byte, rsp_last_of_message};
            case (seen.kind)
               vlmd_pkg::KIND_HDR: hdr_seen++;
               vlmd_pkg::KIND_PAY: pay_seen++;
               default:  err_seen++;
            endcase
            if (frames_due.size() == 0) begin
               flag($sformatf("unexpected result kind=%0d type=%02h len=%0d byte=%02h last=%0b",
                              seen.kind, seen.msg_class, seen.payload_len,
                              seen.payload_byte, seen.last));
            end else begin
               if (seen !== frames_due[0])
                  flag($sformatf({"result mismatch exp kind=%0d type=%02h len=%0d byte=%02h ",
                                  "last=%0b got kind=%0d type=%02h len=%0d byte=%02h last=%0b"},
                                 frames_due[0].kind, frames_due[0].msg_class,
                                 frames_due[0].payload_len, frames_due[0].payload_byte,
                                 frames_due[0].last, seen.kind, seen.msg_class,
                                 seen.payload_len, seen.payload_byte, seen.last));
               void'(frames_due.pop_front());
            end
            if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
            recv_gap = pick_gap(recv_calm);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      build_stream();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (stream_bytes.size() > 0 || frames_due.size() > 0 || push) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames_due.size() > 0) flag($sformatf("%0d results never arrived", frames_due.size()));
      $display("covered %0d stream bytes: %0d headers, %0d payload bytes, %0d length errors",
               bytes_sent, hdr_seen, pay_seen, err_seen);
      $display("failures counted: %0d", errors);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
